@@ rtl/hccs_pkg.sv @@
// Shared types and constants for the hierarchical cell containment search.
// Used by the controller, the datapath and the top level.
package hccs_pkg;

   // Cell identifier layout
   localparam int CELL_W        = 64;
   localparam int TOP_SKIP_BITS = 8;
   localparam int RES_BITS      = 4;
   localparam int BASE_BITS     = 7;
   localparam int DIGIT_BITS    = 3;
   localparam int RES_MSB       = CELL_W - TOP_SKIP_BITS - 1;
   localparam int RES_LSB       = RES_MSB - RES_BITS + 1;
   localparam int BODY_W        = RES_LSB;
   localparam int PREFIX_W      = 6;

   // Field widths of the request and the count register
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // Request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic mem_wr;
      logic start;
      logic issue_rd;
      logic step;
      logic deliver;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic searching;
      logic rsp_free;
   } dpath_stat_type;

   // Mask that keeps the top 'common' bits of a cell body
   function automatic logic [BODY_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] common);
      logic [BODY_W-1:0] m;
      m = '0;
      for (int i = 0; i < BODY_W; i++) begin
         m[i] = ((7'(i) + 7'(common)) >= 7'(BODY_W));
      end
      return m;
   endfunction

endpackage

@@ rtl/hierarchical_cell_containment_search.sv @@
// Hierarchical cell containment search, top level.
// Write request: taken every cycle while no query is in flight, no result. Query: each
// probe is a memory read, then a compare; at most 12 probes at 1024 entries.
// The next request is taken the cycle after the result loads; a stalled result holds the
// next query in its last state. Synchronous active-high reset clears control and the count;
// table is not cleared.
module hierarchical_cell_containment_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [hccs_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [hccs_pkg::CELL_W-1:0]    req_cell_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_contained,
   input  logic                           csr_wr_en,
   input  logic [hccs_pkg::COUNT_W-1:0]   csr_wr_data
);
   import hccs_pkg::*;

   ctrl_cmd_type   cmd;
   dpath_stat_type stat;

   // Sequencer
   hccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Table, compare and result
   hccs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_entry_index (req_entry_index),
      .req_cell_value  (req_cell_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_contained   (rsp_contained),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

@@ rtl/hccs_ctrl.sv @@
// Search controller: sequences table writes, probes and result delivery.
// Depends on hccs_pkg.
module hccs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   output logic                    req_stall,
   input  hccs_pkg::dpath_stat_type stat,
   output hccs_pkg::ctrl_cmd_type   cmd
);
   import hccs_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_WRITE)) begin
               cmd.mem_wr = 1'b1;
            end
            if (accept && (req_opcode == OP_QUERY)) begin
               cmd.start = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.searching) begin
               cmd.issue_rd = 1'b1;
               state_in     = ST_COMPARE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/hccs_dpath.sv @@
// Search datapath: cell table memory, search bounds, probe compare, count
// register and result register. Depends on hccs_pkg.
module hccs_dpath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [hccs_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [hccs_pkg::CELL_W-1:0]         req_cell_value,
   input  logic                                csr_wr_en,
   input  logic [hccs_pkg::COUNT_W-1:0]        csr_wr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_contained,
   input  hccs_pkg::ctrl_cmd_type              cmd,
   output hccs_pkg::dpath_stat_type            stat
);
   import hccs_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [CELL_W-1:0] mem [TABLE_DEPTH];
   logic [CELL_W-1:0] rd_data_ff;
   logic [CELL_W-1:0] query_ff;

   logic [COUNT_W-1:0] entry_count_ff;
   logic [CNT_W-1:0]   n_ff, lo_ff, lo_in, hi_ff, hi_in, probe_ff, probe_in;
   logic               stop_ff, stop_in, found_ff, found_in;
   logic               rsp_valid_ff, rsp_contained_ff;

   logic [31:0]        wr_idx_ext, cnt_ext;
   logic [CNT_W-1:0]   n_sat, mid;
   logic [BODY_W-1:0]  q_body, e_body, mask;
   logic [RES_BITS-1:0] rq, re, rmin;
   logic [PREFIX_W-1:0] common;
   logic               related, equal, less;

   // Count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // Table memory: one write port, one registered read port
   assign wr_idx_ext = 32'(req_entry_index);
   always_ff @(posedge clock) begin
      if (cmd.mem_wr && (wr_idx_ext < 32'(TABLE_DEPTH))) begin
         mem[wr_idx_ext[IDX_W-1:0]] <= req_cell_value;
      end
      if (cmd.issue_rd) begin
         rd_data_ff <= mem[probe_in[IDX_W-1:0]];
      end
   end

   // Count saturated to table depth
   assign cnt_ext = 32'(entry_count_ff);
   assign n_sat   = (cnt_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_ext);

   // Probe selection: first entry, then last entry, then midpoint
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   always_comb begin
      priority if (lo_ff == '0) begin
         probe_in = '0;
      end else if (hi_ff == n_ff) begin
         probe_in = n_ff - CNT_W'(1);
      end else begin
         probe_in = mid;
      end
   end

   // Shared-prefix compare of query and probed entry
   assign q_body  = query_ff[BODY_W-1:0];
   assign e_body  = rd_data_ff[BODY_W-1:0];
   assign rq      = query_ff[RES_MSB:RES_LSB];
   assign re      = rd_data_ff[RES_MSB:RES_LSB];
   assign rmin    = (rq < re) ? rq : re;
   assign common  = PREFIX_W'(BASE_BITS) + PREFIX_W'({rmin, 1'b0}) + PREFIX_W'(rmin);
   assign mask    = prefix_mask(common);
   assign related = (((q_body ^ e_body) & mask) == '0);
   assign equal   = (q_body == e_body);
   assign less    = (q_body < e_body);

   // Bound update
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      stop_in  = stop_ff;
      found_in = found_ff;
      if (cmd.start) begin
         lo_in    = '0;
         hi_in    = n_sat;
         stop_in  = 1'b0;
         found_in = 1'b0;
      end else if (cmd.step) begin
         priority if (equal || (related && less)) begin
            stop_in  = 1'b1;
            found_in = 1'b1;
         end else if (related) begin
            stop_in = 1'b1;
         end else if (less) begin
            hi_in = probe_ff;
         end else begin
            lo_in = probe_ff + CNT_W'(1);
         end
      end
   end

   // Search registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         query_ff <= req_cell_value;
         n_ff     <= n_sat;
      end
      if (cmd.issue_rd) begin
         probe_ff <= probe_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      stop_ff  <= stop_in;
      found_ff <= found_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.deliver) begin
         rsp_contained_ff <= found_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_contained  = rsp_contained_ff;
   assign stat.searching = (lo_ff < hi_ff) && !stop_ff;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

@@ rtl/hccs_checker.sv @@
// Port-level checks for the hierarchical cell containment search.
// Depends on hccs_pkg; bound to the top level below.
module hccs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_opcode,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_contained
);
   import hccs_pkg::*;

   // A held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_contained))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted query occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_QUERY) |=> req_stall)
      else $error("request taken while query in flight");

   // A write request never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after write request");

endmodule

bind hierarchical_cell_containment_search hccs_checker u_hccs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_opcode    (req_opcode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_contained (rsp_contained)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for hierarchical_cell_containment_search.
// Loads cell tables, issues containment queries and checks each answer against
// a local probe-by-probe predictor. Depends on hccs_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
   import hccs_pkg::*;

   localparam int DEPTH = 1024;
   localparam int SETTLE_CYCLES = 40;

   typedef enum {
      REL_SAME, REL_DESCENDANT, REL_ANCESTOR, REL_BELOW, REL_ABOVE
   } cell_relation_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_WRITE;
   logic [INDEX_W-1:0]   req_entry_index = '0;
   logic [CELL_W-1:0]    req_cell_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_contained;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;

   // Local copy of the table and the count register
   logic [CELL_W-1:0]    cell_model [DEPTH];
   int unsigned          count_model = 0;

   bit                   expected_contained [$];
   int                   mismatches = 0;
   int                   requests_sent = 0;
   bit                   steady = 1'b0;   // no idling on either side while set

   hierarchical_cell_containment_search #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_cell_value  (req_cell_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_contained   (rsp_contained),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Cell helpers and containment predictor
   // ---------------------------------------------------------------
   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] low_mask(input int w);
      return (64'd1 << w) - 64'd1;
   endfunction

   // Body bits below the resolution's digits are all ones
   function automatic logic [63:0] make_cell(input int r, input logic [63:0] p,
                                             input logic [7:0] top);
      int          tail;
      logic [63:0] body;
      tail = BODY_W - BASE_BITS - DIGIT_BITS * r;
      body = (p << tail) | low_mask(tail);
      return {top, 4'(r), body[BODY_W-1:0]};
   endfunction

   function automatic int cell_res(input logic [63:0] c);
      return int'(c[RES_MSB:RES_LSB]);
   endfunction

   function automatic logic [63:0] cell_prefix(input logic [63:0] c);
      logic [63:0] body;
      body = 64'(c[BODY_W-1:0]);
      return body >> (BODY_W - BASE_BITS - DIGIT_BITS * cell_res(c));
   endfunction

   // Compare on the prefix shared at the coarser of the two resolutions
   function automatic cell_relation_type compare_cells(input logic [63:0] q,
                                                       input logic [63:0] e);
      logic [BODY_W-1:0] qb, eb;
      int                rmin, shift;
      qb    = q[BODY_W-1:0];
      eb    = e[BODY_W-1:0];
      rmin  = cell_res(q) < cell_res(e) ? cell_res(q) : cell_res(e);
      shift = BODY_W - BASE_BITS - DIGIT_BITS * rmin;
      if (qb == eb)
         return REL_SAME;
      if ((qb >> shift) == (eb >> shift))
         return qb < eb ? REL_DESCENDANT : REL_ANCESTOR;
      return qb < eb ? REL_BELOW : REL_ABOVE;
   endfunction

   function automatic bit cells_unrelated(input logic [63:0] a, input logic [63:0] b);
      cell_relation_type rel;
      rel = compare_cells(a, b);
      return rel == REL_BELOW || rel == REL_ABOVE;
   endfunction

   // Binary search: entry 0 first, then the last entry, then midpoints
   function automatic bit predict_containment(input logic [63:0] q);
      int unsigned n, lo, hi, k;
      n  = count_model > DEPTH ? DEPTH : count_model;
      lo = 0;
      hi = n;
      while (lo < hi) begin
         if (lo == 0)
            k = 0;
         else if (hi == n)
            k = n - 1;
         else
            k = lo + (hi - lo) / 2;
         case (compare_cells(q, cell_model[k]))
            REL_SAME, REL_DESCENDANT: return 1'b1;
            REL_ANCESTOR: return 1'b0;
            REL_BELOW: hi = k;
            default: lo = k + 1;
         endcase
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // Request driver, count register writes, drain
   // ---------------------------------------------------------------
   task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [CELL_W-1:0] cell_word);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_cell_value  <= cell_word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // accepted at this edge
      if (op == OP_QUERY)
         expected_contained.push_back(predict_containment(cell_word));
      else
         cell_model[idx] = cell_word;
      requests_sent++;
   endtask

   task automatic send_query(input logic [CELL_W-1:0] cell_word);
      send_request(OP_QUERY, INDEX_W'($urandom), cell_word);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_contained.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input int unsigned value);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      count_model = value & ((1 << COUNT_W) - 1);
   endtask

   // ---------------------------------------------------------------
   // Stimulus generators
   // ---------------------------------------------------------------
   // Query shaped against the first n entries: copies, descendants,
   // ancestors, near misses, random cells and raw words
   function automatic logic [63:0] pick_query(input int n);
      int          sel, k, re, rq;
      logic [63:0] e, pe;
      logic [7:0]  top;
      sel = $urandom_range(99);
      top = 8'($urandom);
      if (n == 0 || sel < 8)
         return rand_word();
      k  = $urandom_range(n - 1);
      e  = cell_model[k];
      re = cell_res(e);
      pe = cell_prefix(e);
      if (sel < 30)
         return {top, e[RES_MSB:0]};
      if (sel < 55 && re < 15) begin
         rq = $urandom_range(15, re + 1);
         return make_cell(rq, (pe << (DIGIT_BITS * (rq - re))) |
                              (rand_word() & low_mask(DIGIT_BITS * (rq - re))), top);
      end
      if (sel < 68 && re > 0) begin
         rq = $urandom_range(re - 1, 0);
         return make_cell(rq, pe >> (DIGIT_BITS * (re - rq)), top);
      end
      if (sel < 86)
         return make_cell(re, (sel[0] ? pe + 1 : pe - 1) &
                              low_mask(BASE_BITS + DIGIT_BITS * re), top);
      rq = $urandom_range(15);
      return make_cell(rq, rand_word() & low_mask(BASE_BITS + DIGIT_BITS * rq), top);
   endfunction

   // Sorted, non-overlapping table in entries 0..n-1 with mixed resolutions
   task automatic load_canonical_table(input int n);
      logic [63:0] staged [DEPTH];
      logic [63:0] space, gap, p, cand;
      int          res, r, idx;
      bit          ascending;
      if (n == 0)
         return;
      res = $urandom_range(15);
      while ((64'd1 << (BASE_BITS + DIGIT_BITS * res)) < n)
         res++;
      space = 64'd1 << (BASE_BITS + DIGIT_BITS * res);
      gap   = (space - n) / n;
      p     = rand_word() % (gap + 1);
      for (int i = 0; i < n; i++) begin
         if (i > 0)
            p = p + 1 + rand_word() % (gap + 1);
         staged[i] = make_cell(res, p, 8'($urandom));
      end
      // coarsen some entries where neither neighbor falls under the parent
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) begin
            r    = $urandom_range(res);
            cand = make_cell(r, cell_prefix(staged[i]) >> (DIGIT_BITS * (res - r)),
                             staged[i][63:56]);
            if ((i == 0 || cells_unrelated(staged[i-1], cand)) &&
                (i == n - 1 || cells_unrelated(cand, staged[i+1])))
               staged[i] = cand;
         end
      end
      ascending = $urandom_range(1);
      for (int i = 0; i < n; i++) begin
         idx = ascending ? i : n - 1 - i;
         send_request(OP_WRITE, INDEX_W'(idx), staged[idx]);
      end
   endtask

   task automatic load_scrambled_table(input int n);
      for (int i = 0; i < n; i++)
         send_request(OP_WRITE, INDEX_W'(i), $urandom_range(1) ? rand_word() : pick_query(0));
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_empty_table();
      write_entry_count(0);
      send_request(OP_WRITE, INDEX_W'(0), '0);
      send_request(OP_WRITE, INDEX_W'(DEPTH - 1), '1);
      send_query('0);
      send_query('1);
      send_query(pick_query(0));
   endtask

   task automatic test_single_entry();
      logic [63:0] p, e, m;
      write_entry_count(1);
      m = low_mask(BASE_BITS + DIGIT_BITS * 5);
      p = rand_word() & m;
      e = make_cell(5, p, 8'hA5);
      send_request(OP_WRITE, INDEX_W'(0), e);
      send_query(e);
      send_query(make_cell(9, (p << 12) | (rand_word() & low_mask(12)), 8'h5A));
      // finest descendant whose digits are all ones has the same body
      send_query(make_cell(15, (p << 30) | low_mask(30), 8'h00));
      send_query(make_cell(2, p >> 9, 8'hFF));
      send_query(make_cell(5, (p - 1) & m, 8'h3C));
      send_query(make_cell(5, (p + 1) & m, 8'hC3));
      send_query('0);
      send_query('1);
   endtask

   task automatic test_non_canonical();
      write_entry_count(5);
      for (int i = 0; i < 5; i++)
         send_request(OP_WRITE, INDEX_W'(i), rand_word());
      for (int i = 0; i < 3; i++)
         send_query(cell_model[$urandom_range(4)]);
      repeat (3) send_query(pick_query(5));
   endtask

   task automatic test_full_table();
      steady = 1'b1;
      write_entry_count(DEPTH);
      load_canonical_table(DEPTH);
      repeat (30) send_query(pick_query(DEPTH));
      steady = 1'b0;
      // count above the depth saturates
      write_entry_count((1 << COUNT_W) - 1);
      repeat (20) send_query(pick_query(DEPTH));
      write_entry_count(DEPTH - 1);
      repeat (20) send_query(pick_query(DEPTH - 1));
   endtask

   // Every entry is written by now, so any count is safe to search
   task automatic test_random_traffic(input int quota);
      int stop, sel, n;
      stop = requests_sent + quota;
      while (requests_sent < stop) begin
         sel = $urandom_range(99);
         if (sel < 10)
            n = 0;
         else if (sel < 75)
            n = $urandom_range(40, 1);
         else
            n = $urandom_range(300, 41);
         steady = ($urandom_range(9) == 0);
         write_entry_count(n);
         if ($urandom_range(9) == 0)
            load_scrambled_table(n);
         else
            load_canonical_table(n);
         // stale entries past the loaded ones join the search
         if ($urandom_range(9) == 0)
            write_entry_count($urandom_range((1 << COUNT_W) - 1));
         repeat ($urandom_range(60, 20)) begin
            if ($urandom_range(19) == 0)
               send_request(OP_WRITE, INDEX_W'($urandom), pick_query(n));
            else
               send_query(pick_query(n));
         end
         steady = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------
   // Result side: random stall and checking
   // ---------------------------------------------------------------
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 34);

   always @(posedge clock) begin : check_response
      bit want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_contained.size() == 0) begin
            $display("%0t: unexpected response, contained %0b", $time, rsp_contained);
            mismatches++;
         end else begin
            want = expected_contained.pop_front();
            if (rsp_contained !== want) begin
               $display("%0t: contained mismatch, expected %0b, actual %0b",
                        $time, want, rsp_contained);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_single_entry();
      test_non_canonical();
      test_full_table();
      test_random_traffic(100);
      wait_until_idle();
      if (mismatches == 0 && expected_contained.size() == 0)
         $display("hierarchical_cell_containment_search regression: pass");
      else
         $display("hierarchical_cell_containment_search regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("hierarchical_cell_containment_search regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/hccs_pkg.sv
rtl/hccs_ctrl.sv
rtl/hccs_dpath.sv
rtl/hierarchical_cell_containment_search.sv
rtl/hccs_checker.sv
tb/tb_top.sv
